FILE: src/rdd_pkg.sv
// ----------------------------------------------------------------------------
// RVL depth decoder package
// Shared types, constants and the nibble decode function.
// ----------------------------------------------------------------------------
package rdd_pkg;

  localparam logic [22:0] MAX_PIXELS        = 23'd4194304;
  localparam logic [22:0] FRAME_PIXELS_RST  = 23'd307200;
  localparam logic [5:0]  SHIFT_LIMIT       = 6'd32;
  localparam logic [5:0]  GROUP_BITS        = 6'd3;

  typedef enum logic [1:0] {
    PH_ZRUN  = 2'd0,
    PH_NCNT  = 2'd1,
    PH_DELTA = 2'd2,
    PH_DONE  = 2'd3
  } phase_e;

  typedef struct packed {
    phase_e      phase;
    logic [31:0] accum;
    logic [5:0]  shift;
    logic [22:0] run_left;
    logic [22:0] pix;
    logic [15:0] prev;
  } dec_state_t;

  typedef struct packed {
    logic [15:0] value;
    logic [22:0] len;
    logic        frame_end;
    logic        last;
  } res_t;

  typedef struct packed {
    dec_state_t st;
    logic       vld;
    res_t       res;
  } step_t;

  localparam dec_state_t STATE_CLEAR = '{
    phase: PH_ZRUN, accum: 32'd0, shift: 6'd0, run_left: 23'd0, pix: 23'd0, prev: 16'd0
  };

  // Decodes one nibble against the current state and frame size.
  function automatic step_t nibble_step(dec_state_t s, logic [3:0] nib, logic [22:0] fs);
    step_t       r;
    logic [31:0] v;
    logic [22:0] remain;
    logic [22:0] len;
    logic [15:0] new_prev;
    r        = '0;
    r.st     = s;
    v        = '0;
    remain   = '0;
    len      = '0;
    new_prev = '0;
    if (s.phase == PH_DONE || s.pix >= fs) begin
      r.st.phase = PH_DONE;
    end else begin
      if (s.shift < SHIFT_LIMIT) begin
        r.st.accum = s.accum | ({29'd0, nib[2:0]} << s.shift);
        r.st.shift = s.shift + GROUP_BITS;
      end
      if (!nib[3]) begin
        v          = r.st.accum;
        r.st.accum = '0;
        r.st.shift = '0;
        remain     = fs - s.pix;
        len        = (v < {9'd0, remain}) ? v[22:0] : remain;
        case (s.phase)
          PH_ZRUN: begin
            if (len != 23'd0) begin
              r.vld       = 1'b1;
              r.res.value = 16'd0;
              r.res.len   = len;
              r.st.pix    = s.pix + len;
              if (r.st.pix >= fs) begin
                r.res.frame_end = 1'b1;
                r.st.phase      = PH_DONE;
              end
            end
            if (r.st.phase != PH_DONE) begin
              r.st.phase = PH_NCNT;
            end
          end
          PH_NCNT: begin
            r.st.run_left = len;
            r.st.phase    = (len == 23'd0) ? PH_ZRUN : PH_DELTA;
          end
          PH_DELTA: begin
            new_prev = v[0] ? (s.prev - v[16:1] - 16'd1) : (s.prev + v[16:1]);
            r.st.prev = new_prev;
            if (s.run_left != 23'd0) begin
              r.st.run_left = s.run_left - 23'd1;
            end
            r.vld       = 1'b1;
            r.res.value = new_prev;
            r.res.len   = 23'd1;
            r.st.pix    = s.pix + 23'd1;
            if (r.st.pix >= fs) begin
              r.res.frame_end = 1'b1;
              r.st.phase      = PH_DONE;
            end else if (r.st.run_left == 23'd0) begin
              r.st.phase = PH_ZRUN;
            end
          end
          default: begin
            r.st.phase = PH_DONE;
          end
        endcase
      end
    end
    return r;
  endfunction

endpackage

FILE: src/rvl_depth_decoder.sv
// ----------------------------------------------------------------------------
// RVL depth decoder
// Decodes compressed depth bytes into zero runs and delta-coded pixels.
// ----------------------------------------------------------------------------
// A taken byte is registered, then decoded into the output buffer registers.
// Throughput: one item per cycle when it gives at most one result and the
// output is not stalled; an item with two results holds the input back until
// both pass the single output port, one result per cycle when not stalled.
// Reset clears the decode state and the buffer count; frame_pixels returns to 307200.
module rvl_depth_decoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [22:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        frame_start_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] pixel_value_o,
  output logic [22:0] run_length_o,
  output logic        frame_end_o,
  output logic        last_o
);

  logic [22:0]        frame_pixels_q;
  logic [22:0]        fs;
  logic               in_valid_q;
  logic [7:0]         data_q;
  logic               start_q;
  rdd_pkg::dec_state_t state_q, state_d, state_base;
  rdd_pkg::step_t     step_hi, step_lo;
  rdd_pkg::res_t      buf_q [2];
  rdd_pkg::res_t      buf_d [2];
  rdd_pkg::res_t      res_hi, res_lo;
  logic [1:0]         cnt_q, cnt_d;
  logic               out_take, buf_free, advance, in_take;

  assign fs = (frame_pixels_q > rdd_pkg::MAX_PIXELS) ? rdd_pkg::MAX_PIXELS : frame_pixels_q;

  assign out_take   = (cnt_q != 2'd0) && !out_stall_i;
  assign buf_free   = (cnt_q == 2'd0) || ((cnt_q == 2'd1) && out_take);
  assign advance    = in_valid_q && buf_free;
  assign in_stall_o = in_valid_q && !buf_free;
  assign in_take    = in_valid_i && !in_stall_o;

  always_comb begin
    state_base = start_q ? rdd_pkg::STATE_CLEAR : state_q;
    step_hi    = rdd_pkg::nibble_step(state_base, data_q[7:4], fs);
    step_lo    = rdd_pkg::nibble_step(step_hi.st, data_q[3:0], fs);
    res_hi      = step_hi.res;
    res_lo      = step_lo.res;
    res_hi.last = !step_lo.vld;
    res_lo.last = 1'b1;
    state_d = state_q;
    buf_d   = buf_q;
    cnt_d   = cnt_q;
    if (advance) begin
      state_d  = step_lo.st;
      cnt_d    = {1'b0, step_hi.vld} + {1'b0, step_lo.vld};
      buf_d[0] = step_hi.vld ? res_hi : res_lo;
      buf_d[1] = res_lo;
    end else if (out_take) begin
      cnt_d    = cnt_q - 2'd1;
      buf_d[0] = buf_q[1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_pixels_q <= rdd_pkg::FRAME_PIXELS_RST;
      in_valid_q     <= 1'b0;
      state_q        <= rdd_pkg::STATE_CLEAR;
      cnt_q          <= 2'd0;
    end else begin
      if (cfg_we_i) begin
        frame_pixels_q <= cfg_wdata_i;
      end
      if (in_take) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      data_q  <= data_byte_i;
      start_q <= frame_start_i;
    end
    buf_q <= buf_d;
  end

  assign out_valid_o   = (cnt_q != 2'd0);
  assign pixel_value_o = buf_q[0].value;
  assign run_length_o  = buf_q[0].len;
  assign frame_end_o   = buf_q[0].frame_end;
  assign last_o        = buf_q[0].last;

endmodule

FILE: src/rdd_checker.sv
// ----------------------------------------------------------------------------
// RVL depth decoder checker
// Port-level properties of the decoder output, bound to the top level.
// ----------------------------------------------------------------------------
module rdd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [15:0] pixel_value_o,
  input logic [22:0] run_length_o,
  input logic        frame_end_o,
  input logic        last_o
);

  // A stalled item stays valid and unchanged.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(pixel_value_o)
      && $stable(run_length_o) && $stable(frame_end_o) && $stable(last_o))
    else $error("output item changed while stalled");

  // The item that completes a frame is the final one of its byte.
  a_end_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && frame_end_o |-> last_o)
    else $error("frame end without last");

  // No empty run is ever shown.
  a_len_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> run_length_o != 23'd0)
    else $error("zero run length");

  // A nonzero depth only comes from a single delta pixel.
  a_delta_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && pixel_value_o != 16'd0 |-> run_length_o == 23'd1)
    else $error("nonzero depth with run length other than one");

endmodule

bind rvl_depth_decoder rdd_checker u_rdd_checker (.*);
